[hdl/bta_pkg.sv]
// Shared types, constants and helper functions of the binary to ASCII number formatter.
package bta_pkg;

    // Mode codes of a request.
    localparam logic [2:0] MODE_U16_DEC = 3'd0;
    localparam logic [2:0] MODE_U8_DEC  = 3'd1;
    localparam logic [2:0] MODE_S16_DEC = 3'd2;
    localparam logic [2:0] MODE_S32_DEC = 3'd3;
    localparam logic [2:0] MODE_HEX8    = 3'd4;

    // ASCII characters.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HEX_A_OFFSET = 8'h37;

    // Magnitudes never exceed the saturation limit, which fits in 27 bits.
    localparam int MAG_W  = 27;
    localparam int HALF_W = 14;
    localparam logic [31:0] SAT_LIMIT = 32'd99999999;

    // Exact divide by 10000 for any 27-bit value: q = (mag * RECIP_10K) >> RECIP_SHIFT.
    localparam int RECIP_W     = 28;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 41;
    localparam logic [RECIP_W-1:0] RECIP_10K = 28'd219902326;
    localparam logic [HALF_W-1:0]  TEN_K     = 14'd10000;

    // Fixed-point digit fractions: the integer digit sits above FRAC_LSB.
    localparam int FRAC_LSB = 34;
    localparam int FRAC_W   = FRAC_LSB + 4;
    localparam int SCALE_W  = 28;
    // ceil(2^34 / 1000) for four digits and ceil(2^34 / 100) for three digits.
    localparam logic [SCALE_W-1:0] SCALE_4DIG = 28'd17179870;
    localparam logic [SCALE_W-1:0] SCALE_3DIG = 28'd171798692;
    localparam int SCALED_W = HALF_W + SCALE_W;

    localparam int BTA_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
        logic       overflow;
    } rsp_t;

    // What the back end has to print for one number.
    typedef struct packed {
        logic [1:0] lit_cnt;
        logic [7:0] lit0;
        logic [7:0] lit1;
        logic [2:0] hi_cnt;
        logic [2:0] lo_cnt;
        logic       ovf;
    } desc_t;

    typedef struct packed {
        desc_t             desc;
        logic [FRAC_W-1:0] f_hi;
        logic [FRAC_W-1:0] f_lo;
    } entry_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + {4'b0, nib};
        end
        return CH_HEX_A_OFFSET + {4'b0, nib};
    endfunction

    // Drop the leading digit of a fraction and scale the rest by ten.
    function automatic logic [FRAC_W-1:0] next_frac(input logic [FRAC_W-1:0] f);
        logic [FRAC_W-1:0] fr;
        fr = {4'b0, f[FRAC_LSB-1:0]};
        return (fr << 3) + (fr << 1);
    endfunction

endpackage

[hdl/bta_front.sv]
// Front end: accepts requests, classifies them and splits the magnitude into digit fractions.
module bta_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bta_pkg::req_t       request,
    output logic [2:0]          inflight,
    output logic                push,
    output bta_pkg::entry_t     push_entry
);

    // Stage 1: raw request.
    logic                        s1_valid_reg;
    bta_pkg::req_t               s1_req_reg;
    // Stage 2: classified magnitude.
    logic                        s2_valid_reg;
    bta_pkg::desc_t              s2_desc_reg;
    logic [bta_pkg::MAG_W-1:0]   s2_mag_reg;
    // Stage 3: upper half of the magnitude.
    logic                        s3_valid_reg;
    bta_pkg::desc_t              s3_desc_reg;
    logic [bta_pkg::MAG_W-1:0]   s3_mag_reg;
    logic [bta_pkg::HALF_W-1:0]  s3_q_reg;
    // Stage 4: both halves.
    logic                        s4_valid_reg;
    bta_pkg::desc_t              s4_desc_reg;
    logic [bta_pkg::HALF_W-1:0]  s4_hi_reg;
    logic [bta_pkg::HALF_W-1:0]  s4_lo_reg;

    logic                        cls_ok;
    bta_pkg::desc_t              cls_desc;
    logic [bta_pkg::MAG_W-1:0]   cls_mag;
    logic                        neg;
    logic [15:0]                 mag16;
    logic [31:0]                 mag32;
    logic                        sat;
    logic [bta_pkg::PROD_W-1:0]  q_prod;
    logic [27:0]                 q_times_10k;
    logic [27:0]                 lo_wide;
    logic [bta_pkg::SCALED_W-1:0] hi_scaled;
    logic [bta_pkg::SCALED_W-1:0] lo_scaled;

    // Classification of the stage 1 request.
    always_comb
    begin
        cls_ok   = 1'b1;
        cls_desc = '0;
        cls_mag  = '0;
        neg      = 1'b0;
        mag16    = s1_req_reg.value[15:0];
        mag32    = s1_req_reg.value;
        sat      = 1'b0;
        case (s1_req_reg.mode)
            bta_pkg::MODE_U16_DEC:
            begin
                cls_mag         = bta_pkg::MAG_W'(s1_req_reg.value[15:0]);
                cls_desc.hi_cnt = 3'd1;
                cls_desc.lo_cnt = 3'd4;
            end
            bta_pkg::MODE_U8_DEC:
            begin
                cls_mag         = bta_pkg::MAG_W'(s1_req_reg.value[7:0]);
                cls_desc.lo_cnt = 3'd3;
            end
            bta_pkg::MODE_S16_DEC:
            begin
                neg = s1_req_reg.value[15];
                if (neg)
                begin
                    mag16 = ~s1_req_reg.value[15:0] + 16'd1;
                end
                cls_mag          = bta_pkg::MAG_W'(mag16);
                cls_desc.lit_cnt = 2'd1;
                cls_desc.lit0    = neg ? bta_pkg::CH_MINUS : bta_pkg::CH_PLUS;
                cls_desc.hi_cnt  = 3'd1;
                cls_desc.lo_cnt  = 3'd4;
            end
            bta_pkg::MODE_S32_DEC:
            begin
                neg = s1_req_reg.value[31];
                if (neg)
                begin
                    mag32 = ~s1_req_reg.value + 32'd1;
                end
                sat              = mag32 > bta_pkg::SAT_LIMIT;
                cls_mag          = sat ? bta_pkg::SAT_LIMIT[bta_pkg::MAG_W-1:0]
                                       : mag32[bta_pkg::MAG_W-1:0];
                cls_desc.lit_cnt = 2'd1;
                cls_desc.lit0    = neg ? bta_pkg::CH_MINUS : bta_pkg::CH_PLUS;
                cls_desc.hi_cnt  = 3'd4;
                cls_desc.lo_cnt  = 3'd4;
                cls_desc.ovf     = sat;
            end
            bta_pkg::MODE_HEX8:
            begin
                cls_desc.lit_cnt = 2'd2;
                cls_desc.lit0    = bta_pkg::hex_char(s1_req_reg.value[7:4]);
                cls_desc.lit1    = bta_pkg::hex_char(s1_req_reg.value[3:0]);
            end
            default:
            begin
                cls_ok = 1'b0;
            end
        endcase
    end

    // Reciprocal multiply gives the exact quotient by ten thousand.
    assign q_prod = bta_pkg::PROD_W'(s2_mag_reg) * bta_pkg::PROD_W'(bta_pkg::RECIP_10K);

    assign q_times_10k = 28'(s3_q_reg) * 28'(bta_pkg::TEN_K);
    assign lo_wide     = 28'(s3_mag_reg) - q_times_10k;

    // A single leading digit needs no scaling beyond a shift.
    always_comb
    begin
        if (s4_desc_reg.hi_cnt == 3'd1)
        begin
            hi_scaled = bta_pkg::SCALED_W'(s4_hi_reg) << bta_pkg::FRAC_LSB;
        end
        else
        begin
            hi_scaled = bta_pkg::SCALED_W'(s4_hi_reg) * bta_pkg::SCALED_W'(bta_pkg::SCALE_4DIG);
        end
        if (s4_desc_reg.lo_cnt == 3'd3)
        begin
            lo_scaled = bta_pkg::SCALED_W'(s4_lo_reg) * bta_pkg::SCALED_W'(bta_pkg::SCALE_3DIG);
        end
        else
        begin
            lo_scaled = bta_pkg::SCALED_W'(s4_lo_reg) * bta_pkg::SCALED_W'(bta_pkg::SCALE_4DIG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg & cls_ok;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
        end
        s2_desc_reg <= cls_desc;
        s2_mag_reg  <= cls_mag;
        s3_desc_reg <= s2_desc_reg;
        s3_mag_reg  <= s2_mag_reg;
        s3_q_reg    <= q_prod[bta_pkg::RECIP_SHIFT +: bta_pkg::HALF_W];
        s4_desc_reg <= s3_desc_reg;
        s4_hi_reg   <= s3_q_reg;
        s4_lo_reg   <= lo_wide[bta_pkg::HALF_W-1:0];
    end

    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg);

    assign push            = s4_valid_reg;
    assign push_entry.desc = s4_desc_reg;
    assign push_entry.f_hi = hi_scaled[bta_pkg::FRAC_W-1:0];
    assign push_entry.f_lo = lo_scaled[bta_pkg::FRAC_W-1:0];

endmodule

[hdl/bta_queue.sv]
// Short FIFO of classified numbers between the front end and the character emitter.
module bta_queue #(
    parameter int Depth = bta_pkg::BTA_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  bta_pkg::entry_t                push_entry,
    input  logic                           pop,
    output logic                           head_valid,
    output bta_pkg::entry_t                head,
    output logic [$clog2(Depth+1)-1:0]     count
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    bta_pkg::entry_t    store_reg [Depth];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(Depth - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = store_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

[hdl/bta_back.sv]
// Character emitter: prints one character of the current number per clock.
module bta_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  bta_pkg::entry_t head,
    output logic            pop,
    output logic            strobe,
    output bta_pkg::rsp_t   result
);

    logic                        active_reg;
    logic [3:0]                  rem_reg;
    logic [1:0]                  lit_cnt_reg;
    logic [2:0]                  hi_cnt_reg;
    logic [2:0]                  lo_cnt_reg;
    logic [7:0]                  lit0_reg;
    logic [7:0]                  lit1_reg;
    logic                        ovf_reg;
    logic [bta_pkg::FRAC_W-1:0]  f_hi_reg;
    logic [bta_pkg::FRAC_W-1:0]  f_lo_reg;
    logic                        strobe_reg;
    bta_pkg::rsp_t               result_reg;

    logic                        last_now;
    logic [bta_pkg::FRAC_W-1:0]  digit_frac;
    logic [7:0]                  ch;

    assign last_now   = active_reg && (rem_reg == 4'd1);
    assign pop        = head_valid && (!active_reg || last_now);
    assign digit_frac = (hi_cnt_reg != 3'd0) ? f_hi_reg : f_lo_reg;
    assign ch         = (lit_cnt_reg != 2'd0) ? lit0_reg
                      : bta_pkg::CH_ZERO + {4'b0, digit_frac[bta_pkg::FRAC_W-1 -: 4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rem_reg     <= '0;
            lit_cnt_reg <= '0;
            hi_cnt_reg  <= '0;
            lo_cnt_reg  <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (pop)
            begin
                active_reg  <= 1'b1;
                rem_reg     <= 4'(head.desc.lit_cnt) + 4'(head.desc.hi_cnt)
                             + 4'(head.desc.lo_cnt);
                lit_cnt_reg <= head.desc.lit_cnt;
                hi_cnt_reg  <= head.desc.hi_cnt;
                lo_cnt_reg  <= head.desc.lo_cnt;
            end
            else if (active_reg)
            begin
                rem_reg <= rem_reg - 4'd1;
                if (last_now)
                begin
                    active_reg <= 1'b0;
                end
                if (lit_cnt_reg != 2'd0)
                begin
                    lit_cnt_reg <= lit_cnt_reg - 2'd1;
                end
                else if (hi_cnt_reg != 3'd0)
                begin
                    hi_cnt_reg <= hi_cnt_reg - 3'd1;
                end
                else if (lo_cnt_reg != 3'd0)
                begin
                    lo_cnt_reg <= lo_cnt_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.text_char <= ch;
        result_reg.last      <= last_now;
        result_reg.overflow  <= ovf_reg;
        if (pop)
        begin
            lit0_reg <= head.desc.lit0;
            lit1_reg <= head.desc.lit1;
            ovf_reg  <= head.desc.ovf;
            f_hi_reg <= head.f_hi;
            f_lo_reg <= head.f_lo;
        end
        else if (active_reg)
        begin
            if (lit_cnt_reg != 2'd0)
            begin
                lit0_reg <= lit1_reg;
            end
            else if (hi_cnt_reg != 3'd0)
            begin
                f_hi_reg <= bta_pkg::next_frac(f_hi_reg);
            end
            else
            begin
                f_lo_reg <= bta_pkg::next_frac(f_lo_reg);
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[hdl/binary_to_ascii_number_formatter.sv]
// Top level of the binary to ASCII number formatter.
// A request (mode and 32-bit value) is taken at a clock edge where start is high and busy is
// low; busy only reflects how much work is already reserved, so requests may follow each other
// on consecutive cycles until the reservations run out. Each request produces its text one
// character per cycle on result, with strobe high for exactly one cycle per character and
// result.last set on the final one. The receiver cannot stall: every strobed character must be
// taken in its cycle. Output rate is one character per clock; a number has 2 characters (hex),
// 3 (unsigned 8-bit), 5 (unsigned 16-bit), 6 (signed 16-bit) or 9 (signed 32-bit), and the
// single character emitter sets the sustained rate. Four front stages classify the value,
// divide it by ten thousand with a reciprocal multiply and turn both halves into scaled digit
// fractions, then the number waits in the queue until the emitter picks it up. Modes 5 to 7
// are dropped in the front end and produce no characters. A signed 32-bit magnitude above
// 99999999 prints as 99999999 with overflow set on all of its characters.
module binary_to_ascii_number_formatter #(
    parameter int QueueDepth = bta_pkg::BTA_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bta_pkg::req_t request,
    output logic          strobe,
    output bta_pkg::rsp_t result
);

    localparam int CNT_W = $clog2(QueueDepth + 1);
    localparam int OCC_W = CNT_W + 3;

    logic              accept;
    logic [2:0]        inflight;
    logic              push;
    bta_pkg::entry_t   push_entry;
    logic              pop;
    logic              head_valid;
    bta_pkg::entry_t   head;
    logic [CNT_W-1:0]  q_count;
    logic [OCC_W-1:0]  occupancy;

    // Every request in the front stages holds a queue slot, so pushes never find it full.
    assign occupancy = OCC_W'(inflight) + OCC_W'(q_count);
    assign busy      = occupancy >= OCC_W'(QueueDepth);
    assign accept    = start && !busy;

    bta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .request    (request),
        .inflight   (inflight),
        .push       (push),
        .push_entry (push_entry)
    );

    bta_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    bta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .strobe     (strobe),
        .result     (result)
    );

endmodule
